@@ sv/arqsw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package arqsw_pkg;

    localparam int SEQ_SPACE = 16;
    localparam int SEQ_W     = 4;
    localparam int TIME_W    = 40;
    localparam int CNT_W     = 32;
    localparam int ATT_W     = 8;
    localparam int OUTS_W    = 5;
    localparam int DIV_BITS  = 40;
    localparam int DCNT_W    = $clog2(DIV_BITS);

    localparam logic [TIME_W-1:0] MIN_TIMEOUT = 40'd50;

    localparam logic [2:0]  DEF_SEQ_BITS  = 3'd4;
    localparam logic [4:0]  DEF_WINDOW    = 5'd8;
    localparam logic [31:0] DEF_GOAL      = 32'd1000;
    localparam logic [23:0] DEF_INIT_TO   = 24'd300000;
    localparam logic [7:0]  DEF_WARMUP    = 8'd10;
    localparam logic [15:0] DEF_FACTOR    = 16'd1500;
    localparam logic [23:0] DEF_THRESHOLD = 24'd500;
    localparam logic [7:0]  DEF_RETRY     = 8'd10;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [2:0] EV_SENT    = 3'd0;
    localparam logic [2:0] EV_RESENT  = 3'd1;
    localparam logic [2:0] EV_ACKED   = 3'd2;
    localparam logic [2:0] EV_REFUSED = 3'd3;
    localparam logic [2:0] EV_NONE    = 3'd4;

    localparam logic [2:0] CFG_SEQ_BITS  = 3'd0;
    localparam logic [2:0] CFG_WINDOW    = 3'd1;
    localparam logic [2:0] CFG_GOAL      = 3'd2;
    localparam logic [2:0] CFG_INIT_TO   = 3'd3;
    localparam logic [2:0] CFG_WARMUP    = 3'd4;
    localparam logic [2:0] CFG_FACTOR    = 3'd5;
    localparam logic [2:0] CFG_THRESHOLD = 3'd6;
    localparam logic [2:0] CFG_RETRY     = 3'd7;

    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic do_send;
        logic tick_prep;
        logic ack_prep;
        logic pick;
        logic ack_sample;
        logic mmul_lo;
        logic mmul_hi;
        logic div_init;
        logic div_step;
        logic ack_commit;
        logic resend;
        logic emit_none;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       finished;
        logic       prep_empty;
        logic       mask_any;
        logic       need_update;
        logic       div_last;
    } t_stat;

    function automatic logic [SEQ_W-1:0] lowest_idx(input logic [SEQ_SPACE-1:0] m);
        logic [SEQ_W-1:0] idx;
        idx = '0;
        for (int i = SEQ_SPACE - 1; i >= 0; i--) begin
            if (m[i]) idx = SEQ_W'(i);
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

@@ sv/arqsw_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module arqsw_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire arqsw_pkg::t_cmd      i_cmd,
    output arqsw_pkg::t_stat          o_stat,
    input  wire logic [1:0]           i_kind,
    input  wire logic [3:0]           i_ack_seq,
    input  wire logic                 i_cfg_valid,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    output logic                      o_valid,
    output logic [2:0]                o_event_res,
    output logic [3:0]                o_seq,
    output logic [31:0]               o_rtt_sample,
    output logic [7:0]                o_attempt_count,
    output logic [39:0]               o_mean_rtt,
    output logic                      o_finished,
    output logic                      o_last
);
    import arqsw_pkg::*;

    // configuration
    logic [2:0]  r_seq_bits;
    logic [4:0]  r_window;
    logic [31:0] r_goal;
    logic [23:0] r_init_to;
    logic [7:0]  r_warmup;
    logic [15:0] r_factor;
    logic [23:0] r_thresh;
    logic [7:0]  r_retry;

    // window state
    logic [SEQ_SPACE-1:0] r_pending;
    logic [TIME_W-1:0]    r_timer [SEQ_SPACE];
    logic [ATT_W-1:0]     r_att   [SEQ_SPACE];
    logic [TIME_W-1:0]    mem_sent [SEQ_SPACE];
    logic [TIME_W-1:0]    r_rd;
    logic [SEQ_W-1:0]     r_next;
    logic [OUTS_W-1:0]    r_outst;
    logic [TIME_W-1:0]    r_now;
    logic [CNT_W-1:0]     r_total;
    logic [CNT_W-1:0]     r_acked;
    logic [TIME_W-1:0]    r_mean;
    logic [ATT_W-1:0]     r_worst;

    // working registers
    logic [1:0]           r_kind;
    logic [SEQ_W-1:0]     r_ack;
    logic [35:0]          r_plo, r_phi;
    logic [SEQ_SPACE-1:0] r_mask;
    logic [SEQ_W-1:0]     r_idx;
    logic [31:0]          r_diff;
    logic                 r_upd;
    logic [51:0]          r_mlo, r_mhi;
    logic [32:0]          r_rem;
    logic [DIV_BITS-1:0]  r_nlo;
    logic [DIV_BITS-1:0]  r_q;
    logic [DCNT_W-1:0]    r_cnt;

    // output beat
    logic        r_ov;
    logic [2:0]  r_ev;
    logic [3:0]  r_oseq;
    logic [31:0] r_ortt;
    logic [7:0]  r_oatt;
    logic [39:0] r_omean;
    logic        r_ofin;
    logic        r_olast;

    logic [SEQ_W-1:0]     seq_mask, slot, pick_idx;
    logic                 finished_now, can_send, emit;
    logic [55:0]          prod;
    logic [TIME_W-1:0]    scaled, raw_to, timeout;
    logic [SEQ_SPACE-1:0] ack_m, tick_m;
    logic [TIME_W-1:0]    diff40;
    logic [31:0]          diff32;
    logic                 need_upd;
    logic [72:0]          numer;
    logic [32:0]          div_d;
    logic [33:0]          div_t, div_sub;
    logic                 div_ge;
    logic [CNT_W-1:0]     acked_inc, total_inc;
    logic [TIME_W-1:0]    mean_new;
    logic                 fin_ack, fin_res;
    logic [ATT_W-1:0]     att_cur, att_inc, worst_new;

    always_comb begin
        case (r_seq_bits)
            3'd0:    seq_mask = 4'h0;
            3'd1:    seq_mask = 4'h1;
            3'd2:    seq_mask = 4'h3;
            3'd3:    seq_mask = 4'h7;
            default: seq_mask = 4'hF;
        endcase
    end

    assign slot         = r_next & seq_mask;
    assign finished_now = (r_acked >= r_goal) || (r_worst > r_retry);
    assign can_send     = !finished_now && (r_outst < r_window) && !r_pending[slot];

    // timeout after warm-up: rtt_factor * mean / 256, saturated to 40 bits
    assign prod    = {r_phi, 20'd0} + {20'd0, r_plo};
    assign scaled  = (|prod[55:48]) ? '1 : prod[47:8];
    assign raw_to  = (r_total < {24'd0, r_warmup}) ? {16'd0, r_init_to} : scaled;
    assign timeout = (raw_to < MIN_TIMEOUT) ? MIN_TIMEOUT : raw_to;

    always_comb begin
        for (int i = 0; i < SEQ_SPACE; i++) begin
            ack_m[i]  = r_pending[i] && (SEQ_W'(i) <= r_ack);
            tick_m[i] = r_pending[i] && (r_timer[i] <= 40'd1);
        end
    end

    assign pick_idx = lowest_idx(r_mask);

    assign diff40   = r_now - r_rd;
    assign diff32   = (|diff40[39:32]) ? '1 : diff40[31:0];
    assign att_cur  = r_att[r_idx];
    assign need_upd = (diff32 < {8'd0, r_thresh}) || (att_cur > 8'd1);

    // mean update: (mean*n + sample*256) / (n+1), one quotient bit a cycle
    assign numer   = {1'b0, r_mhi, 20'd0} + {21'd0, r_mlo} + {33'd0, r_diff, 8'd0};
    assign div_d   = {1'b0, r_acked} + 33'd1;
    assign div_t   = {r_rem, r_nlo[DIV_BITS-1]};
    assign div_ge  = div_t >= {1'b0, div_d};
    assign div_sub = div_t - {1'b0, div_d};

    assign acked_inc = (r_acked == '1) ? r_acked : r_acked + 32'd1;
    assign total_inc = (r_total == '1) ? r_total : r_total + 32'd1;
    assign mean_new  = r_upd ? r_q : r_mean;
    assign fin_ack   = (acked_inc >= r_goal) || (r_worst > r_retry);
    assign att_inc   = (att_cur == '1) ? att_cur : att_cur + 8'd1;
    assign worst_new = (att_cur > r_worst) ? att_cur : r_worst;
    assign fin_res   = (r_acked >= r_goal) || (worst_new > r_retry);

    assign emit = i_cmd.do_send | i_cmd.emit_none | i_cmd.ack_commit | i_cmd.resend;

    always_comb begin
        o_stat.kind        = r_kind;
        o_stat.finished    = finished_now;
        o_stat.prep_empty  = (r_kind == KIND_ACK) ? (ack_m == '0) : (tick_m == '0);
        o_stat.mask_any    = |r_mask;
        o_stat.need_update = r_upd;
        o_stat.div_last    = (r_cnt == DCNT_W'(DIV_BITS - 1));
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_bits <= DEF_SEQ_BITS;
            r_window   <= DEF_WINDOW;
            r_goal     <= DEF_GOAL;
            r_init_to  <= DEF_INIT_TO;
            r_warmup   <= DEF_WARMUP;
            r_factor   <= DEF_FACTOR;
            r_thresh   <= DEF_THRESHOLD;
            r_retry    <= DEF_RETRY;
            r_pending  <= '0;
            r_next     <= '0;
            r_outst    <= '0;
            r_now      <= '0;
            r_total    <= '0;
            r_acked    <= '0;
            r_mean     <= '0;
            r_worst    <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SEQ_BITS:  r_seq_bits <= i_cfg_data[2:0];
                    CFG_WINDOW:    r_window   <= i_cfg_data[4:0];
                    CFG_GOAL:      r_goal     <= i_cfg_data;
                    CFG_INIT_TO:   r_init_to  <= i_cfg_data[23:0];
                    CFG_WARMUP:    r_warmup   <= i_cfg_data[7:0];
                    CFG_FACTOR:    r_factor   <= i_cfg_data[15:0];
                    CFG_THRESHOLD: r_thresh   <= i_cfg_data[23:0];
                    CFG_RETRY:     r_retry    <= i_cfg_data[7:0];
                    default:       r_retry    <= r_retry;
                endcase
            end
            if (i_cmd.do_send && can_send) begin
                r_pending[slot] <= 1'b1;
                r_outst         <= r_outst + 5'd1;
                r_total         <= total_inc;
                r_next          <= (slot + 4'd1) & seq_mask;
            end
            if (i_cmd.tick_prep) r_now <= r_now + 40'd1;
            if (i_cmd.ack_commit) begin
                r_pending[r_idx] <= 1'b0;
                if (r_outst != '0) r_outst <= r_outst - 5'd1;
                r_mean  <= mean_new;
                r_acked <= acked_inc;
            end
            if (i_cmd.resend) begin
                r_total <= total_inc;
                r_worst <= worst_new;
            end
            r_ov <= emit;
        end
    end

    // send-time store
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_send && can_send) mem_sent[slot] <= r_now;
        if (i_cmd.pick) r_rd <= mem_sent[pick_idx];
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_ack  <= i_ack_seq;
        end
        if (i_cmd.mul_lo) r_plo <= {20'd0, r_factor} * {16'd0, r_mean[19:0]};
        if (i_cmd.mul_hi) r_phi <= {20'd0, r_factor} * {16'd0, r_mean[39:20]};
        if (i_cmd.do_send && can_send) begin
            r_timer[slot] <= timeout;
            r_att[slot]   <= 8'd1;
        end
        if (i_cmd.tick_prep) begin
            for (int i = 0; i < SEQ_SPACE; i++) begin
                if (r_pending[i] && (r_timer[i] > 40'd1)) r_timer[i] <= r_timer[i] - 40'd1;
            end
            r_mask <= tick_m;
        end
        if (i_cmd.ack_prep) r_mask <= ack_m;
        if (i_cmd.pick) begin
            r_idx            <= pick_idx;
            r_mask[pick_idx] <= 1'b0;
        end
        if (i_cmd.ack_sample) begin
            r_diff <= diff32;
            r_upd  <= need_upd;
        end
        if (i_cmd.mmul_lo) r_mlo <= {32'd0, r_mean[19:0]} * {20'd0, r_acked};
        if (i_cmd.mmul_hi) r_mhi <= {32'd0, r_mean[39:20]} * {20'd0, r_acked};
        if (i_cmd.div_init) begin
            r_rem <= numer[72:40];
            r_nlo <= numer[39:0];
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_sub[32:0] : div_t[32:0];
            r_nlo <= {r_nlo[DIV_BITS-2:0], 1'b0};
            r_q   <= {r_q[DIV_BITS-2:0], div_ge};
            r_cnt <= r_cnt + DCNT_W'(1);
        end
        if (i_cmd.ack_commit) r_timer[r_idx] <= '0;
        if (i_cmd.resend) begin
            r_timer[r_idx] <= timeout;
            r_att[r_idx]   <= att_inc;
        end

        if (i_cmd.do_send) begin
            r_ev    <= can_send ? EV_SENT : EV_REFUSED;
            r_oseq  <= slot;
            r_ortt  <= '0;
            r_oatt  <= can_send ? 8'd1 : 8'd0;
            r_omean <= r_mean;
            r_ofin  <= finished_now;
            r_olast <= 1'b1;
        end else if (i_cmd.emit_none) begin
            r_ev    <= EV_NONE;
            r_oseq  <= '0;
            r_ortt  <= '0;
            r_oatt  <= '0;
            r_omean <= r_mean;
            r_ofin  <= finished_now;
            r_olast <= 1'b1;
        end else if (i_cmd.ack_commit) begin
            r_ev    <= EV_ACKED;
            r_oseq  <= r_idx;
            r_ortt  <= r_diff;
            r_oatt  <= att_cur;
            r_omean <= mean_new;
            r_ofin  <= fin_ack;
            r_olast <= (r_mask == '0);
        end else if (i_cmd.resend) begin
            r_ev    <= EV_RESENT;
            r_oseq  <= r_idx;
            r_ortt  <= '0;
            r_oatt  <= att_inc;
            r_omean <= r_mean;
            r_ofin  <= fin_res;
            r_olast <= (r_mask == '0);
        end
    end

    assign o_valid         = r_ov;
    assign o_event_res     = r_ev;
    assign o_seq           = r_oseq;
    assign o_rtt_sample    = r_ortt;
    assign o_attempt_count = r_oatt;
    assign o_mean_rtt      = r_omean;
    assign o_finished      = r_ofin;
    assign o_last          = r_olast;

endmodule
`default_nettype wire

@@ sv/arqsw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module arqsw_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire arqsw_pkg::t_stat i_stat,
    output arqsw_pkg::t_cmd      o_cmd,
    output logic                 o_busy
);
    import arqsw_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_MUL_LO   = 13'b0000000000010,
        S_MUL_HI   = 13'b0000000000100,
        S_DISPATCH = 13'b0000000001000,
        S_APICK    = 13'b0000000010000,
        S_ARD      = 13'b0000000100000,
        S_ADEC     = 13'b0000001000000,
        S_MMUL_HI  = 13'b0000010000000,
        S_DIV_INIT = 13'b0000100000000,
        S_DIV      = 13'b0001000000000,
        S_ACOMMIT  = 13'b0010000000000,
        S_TPICK    = 13'b0100000000000,
        S_RESEND   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                if (i_stat.kind == KIND_SEND) begin
                    o_cmd.do_send = 1'b1;
                end else if (i_stat.kind == KIND_ACK) begin
                    if (i_stat.finished || i_stat.prep_empty) begin
                        o_cmd.emit_none = 1'b1;
                    end else begin
                        o_cmd.ack_prep = 1'b1;
                        n_state        = S_APICK;
                    end
                end else if (i_stat.kind == KIND_TICK) begin
                    o_cmd.tick_prep = 1'b1;
                    if (i_stat.prep_empty) o_cmd.emit_none = 1'b1;
                    else n_state = S_TPICK;
                end else begin
                    o_cmd.emit_none = 1'b1;
                end
            end
            S_APICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_ARD;
            end
            S_ARD: begin
                o_cmd.ack_sample = 1'b1;
                n_state          = S_ADEC;
            end
            S_ADEC: begin
                if (i_stat.need_update) begin
                    o_cmd.mmul_lo = 1'b1;
                    n_state       = S_MMUL_HI;
                end else begin
                    o_cmd.ack_commit = 1'b1;
                    n_state          = i_stat.mask_any ? S_APICK : S_IDLE;
                end
            end
            S_MMUL_HI: begin
                o_cmd.mmul_hi = 1'b1;
                n_state       = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_ACOMMIT;
            end
            S_ACOMMIT: begin
                o_cmd.ack_commit = 1'b1;
                n_state          = i_stat.mask_any ? S_APICK : S_IDLE;
            end
            S_TPICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_RESEND;
            end
            S_RESEND: begin
                o_cmd.resend = 1'b1;
                n_state      = i_stat.mask_any ? S_TPICK : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

@@ sv/arq_sender_window.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Selective-repeat ARQ sender window. Raise start with i_kind (send, ack or
// tick) and i_ack_seq while busy is low; the item is taken on that edge and
// busy stays high until its last result has gone out. Results appear one per
// o_valid pulse and must be captured in that cycle: there is no way to stall
// them, and o_last marks the final beat of the item. Every item passes load,
// the timeout multiply and dispatch. A tick adds pick and resend per expired
// entry; an ack adds pick, sample and decide per cleared entry, plus mean
// multiply, divide set-up, divide and commit for each entry whose sample
// enters the mean: the mean divide produces one quotient bit per cycle.
// Configuration writes go through i_cfg_valid/o_cfg_ready (always ready)
// and are to be made only while busy is low.
module arq_sender_window (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [3:0]  i_ack_seq,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_valid,
    output logic [2:0]       o_event_res,
    output logic [3:0]       o_seq,
    output logic [31:0]      o_rtt_sample,
    output logic [7:0]       o_attempt_count,
    output logic [39:0]      o_mean_rtt,
    output logic             o_finished,
    output logic             o_last
);
    import arqsw_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: one item at a time, one command set per cycle
    arqsw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // window entries, timers, mean divider and the output beat register
    arqsw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_kind),
        .i_ack_seq       (i_ack_seq),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_event_res     (o_event_res),
        .o_seq           (o_seq),
        .o_rtt_sample    (o_rtt_sample),
        .o_attempt_count (o_attempt_count),
        .o_mean_rtt      (o_mean_rtt),
        .o_finished      (o_finished),
        .o_last          (o_last)
    );

    // registers take writes in any cycle
    assign o_cfg_ready = 1'b1;

    // the last beat of an item coincides with the return to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("last beat while still busy");

    // more beats are coming, so the sequencer must still be working
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("intermediate beat while idle");

    // an accepted item always occupies the block
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("item accepted but block not busy");

endmodule
`default_nettype wire
